// ----- rtl/core/csrt_pkg.sv -----
// csrt_pkg: shared types, widths and codes for the client strength rank table.
// No dependencies; used by csrt_cell and client_strength_rank_table.
package csrt_pkg;

	localparam int ENTRIES = 16;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int FUNC_W  = 2;
	localparam int KEY_W   = 10;
	localparam int STR_W   = 16;
	localparam int PRIO_W  = 5;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ERASE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RANK   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KD_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KD_ENTRY  = 2'd1;
	localparam logic [KIND_W-1:0] KD_EMPTY  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

	typedef enum logic [2:0] {
		C_NONE,
		C_INS,
		C_ERA,
		C_LOAD,
		C_ROT,
		C_FIN
	} cell_op_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t                op;
		logic [KEY_W-1:0]        key;
		logic signed [STR_W-1:0] str;
		logic                    any_hit;
	} cell_ctl_t;

	// token that circulates around the ring during rank
	typedef struct packed {
		logic                    vld;
		logic signed [STR_W-1:0] str;
		logic [SLOT_W-1:0]       slot;
	} tok_t;

	// stored entry as seen from outside a cell
	typedef struct packed {
		logic                    vld;
		logic [KEY_W-1:0]        key;
		logic signed [STR_W-1:0] str;
		logic [PRIO_W-1:0]       prio;
	} ent_t;

endpackage

// ----- rtl/core/client_strength_rank_table.sv -----
// client_strength_rank_table: top level; a ring of csrt_cell slots plus the
// operation sequencer and the result register. Uses csrt_pkg, csrt_cell.
//
// Usage:
//   Commands arrive as beats on the s_axis channel (insert/update, erase,
//   rank). Results leave as beats on the m_axis channel; tuser carries the
//   result kind and tlast marks the final beat caused by one command.
//   Insert and erase are done in the accept cycle: the single status beat is
//   presented on the next cycle. Rank loads a token into each of the ENTRIES
//   slots, rotates the ring so every slot sees every other slot's strength,
//   stores the new priorities, then scans the slots one per cycle while the
//   result register is free and emits a beat for each occupied one.
//   An empty table on rank gives one beat of kind "empty" right away.
//   Commands are taken one at a time: s_axis_tready is high only while no
//   rank is in progress and the result register is free or being drained.
//   When m_axis_tready is low the result beat holds and the slot scan waits.
//   Reset clears all valid flags and the sequencer; stored keys, strengths
//   and priorities are only read for occupied slots. Opcode 3 is taken and
//   ignored.
module client_strength_rank_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [1:0] func, [11:2] client_key, [27:12] strength, [31:28] zero
	input  logic [csrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [1:0] status, [11:2] client_key_res, [27:12] strength_res,
	// [32:28] priority_res, [39:33] zero
	output logic [csrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// [1:0] kind
	output logic [csrt_pkg::KIND_W-1:0]       m_axis_tuser,
	output logic                              m_axis_tlast
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROT,
		S_FIN,
		S_RPT
	} state_t;

	localparam int ENTRIES = csrt_pkg::ENTRIES;
	localparam int SLOT_W  = csrt_pkg::SLOT_W;

	state_t                              state_q;
	logic [SLOT_W-1:0]                   step_q;

	// result register
	logic                                ovld_q;
	logic [csrt_pkg::KIND_W-1:0]         okind_q;
	logic [csrt_pkg::STAT_W-1:0]         ostat_q;
	logic [csrt_pkg::KEY_W-1:0]          okey_q;
	logic signed [csrt_pkg::STR_W-1:0]   ostr_q;
	logic [csrt_pkg::PRIO_W-1:0]         oprio_q;
	logic                                olast_q;

	// command fields
	logic [csrt_pkg::FUNC_W-1:0]         in_func;
	logic [csrt_pkg::KEY_W-1:0]          in_key;
	logic signed [csrt_pkg::STR_W-1:0]   in_str;

	logic                                accept;
	logic                                ofree;
	logic                                out_load;
	csrt_pkg::cell_ctl_t                 ctl;

	logic [ENTRIES:0]                    hit_chain;
	logic [ENTRIES:0]                    free_chain;
	csrt_pkg::tok_t                      tok [ENTRIES];
	csrt_pkg::ent_t                      ent [ENTRIES];

	logic [ENTRIES-1:0]                  vld_vec;
	logic                                any_vld;
	logic                                vld_above;
	csrt_pkg::ent_t                      cur;

	assign in_func = s_axis_tdata[1:0];
	assign in_key  = s_axis_tdata[11:2];
	assign in_str  = s_axis_tdata[27:12];

	assign ofree         = !ovld_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && ofree;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// a new beat enters the result register this cycle
	assign out_load = (accept && ((in_func == csrt_pkg::FN_INSERT) ||
		(in_func == csrt_pkg::FN_ERASE) ||
		((in_func == csrt_pkg::FN_RANK) && !any_vld))) ||
		((state_q == S_RPT) && ofree && cur.vld);

	// cell command for this cycle
	always_comb begin
		ctl.op      = csrt_pkg::C_NONE;
		ctl.key     = in_key;
		ctl.str     = in_str;
		ctl.any_hit = hit_chain[ENTRIES];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_func)
						csrt_pkg::FN_INSERT: ctl.op = csrt_pkg::C_INS;
						csrt_pkg::FN_ERASE:  ctl.op = csrt_pkg::C_ERA;
						csrt_pkg::FN_RANK:   ctl.op = csrt_pkg::C_LOAD;
						default:             ctl.op = csrt_pkg::C_NONE;
					endcase
				end
			end
			S_ROT:   ctl.op = csrt_pkg::C_ROT;
			S_FIN:   ctl.op = csrt_pkg::C_FIN;
			default: ctl.op = csrt_pkg::C_NONE;
		endcase
	end

	assign hit_chain[0]  = 1'b0;
	assign free_chain[0] = 1'b0;

	// ring of slots; token passes from slot g-1 to slot g, last wraps to first
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		csrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.idx      (SLOT_W'(g)),
			.hit_in   (hit_chain[g]),
			.free_in  (free_chain[g]),
			.hit_out  (hit_chain[g+1]),
			.free_out (free_chain[g+1]),
			.tok_in   (tok[(g + ENTRIES - 1) % ENTRIES]),
			.tok_out  (tok[g]),
			.ent      (ent[g])
		);
		assign vld_vec[g] = ent[g].vld;
	end

	assign any_vld = |vld_vec;
	assign cur     = ent[step_q];

	// any occupied slot after the one being reported
	always_comb begin
		vld_above = 1'b0;
		for (int k = 0; k < ENTRIES; k++) begin
			if (vld_vec[k] && (SLOT_W'(k) > step_q)) begin
				vld_above = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			ovld_q  <= 1'b0;
			okind_q <= '0;
			ostat_q <= '0;
			okey_q  <= '0;
			ostr_q  <= '0;
			oprio_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_func)
							csrt_pkg::FN_INSERT: begin
								okind_q <= csrt_pkg::KD_STATUS;
								okey_q  <= in_key;
								oprio_q <= '0;
								olast_q <= 1'b1;
								if (!hit_chain[ENTRIES] && !free_chain[ENTRIES]) begin
									ostat_q <= csrt_pkg::ST_FULL;
									ostr_q  <= '0;
								end else begin
									ostat_q <= csrt_pkg::ST_DONE;
									ostr_q  <= in_str;
								end
							end
							csrt_pkg::FN_ERASE: begin
								okind_q <= csrt_pkg::KD_STATUS;
								okey_q  <= in_key;
								ostr_q  <= '0;
								oprio_q <= '0;
								olast_q <= 1'b1;
								if (!hit_chain[ENTRIES]) begin
									ostat_q <= csrt_pkg::ST_ABSENT;
								end else begin
									ostat_q <= csrt_pkg::ST_DONE;
								end
							end
							csrt_pkg::FN_RANK: begin
								if (any_vld) begin
									state_q <= S_ROT;
									step_q  <= '0;
								end else begin
									okind_q <= csrt_pkg::KD_EMPTY;
									ostat_q <= csrt_pkg::ST_DONE;
									okey_q  <= '0;
									ostr_q  <= '0;
									oprio_q <= '0;
									olast_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ROT: begin
					if (step_q == SLOT_W'(ENTRIES - 2)) begin
						state_q <= S_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FIN: begin
					state_q <= S_RPT;
					step_q  <= '0;
				end
				S_RPT: begin
					if (ofree) begin
						if (cur.vld) begin
							okind_q <= csrt_pkg::KD_ENTRY;
							ostat_q <= csrt_pkg::ST_DONE;
							okey_q  <= cur.key;
							ostr_q  <= cur.str;
							oprio_q <= cur.prio;
							olast_q <= !vld_above;
						end
						if (step_q == SLOT_W'(ENTRIES - 1)) begin
							state_q <= S_IDLE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {7'd0, oprio_q, ostr_q, okey_q, ostat_q};

endmodule

// ----- rtl/core/csrt_cell.sv -----
// csrt_cell: one table slot; holds an entry, joins the key search chains and
// counts stronger entries as the rank token ring passes by. Uses csrt_pkg.
module csrt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  csrt_pkg::cell_ctl_t        ctl,
	input  logic [csrt_pkg::SLOT_W-1:0] idx,
	input  logic                       hit_in,
	input  logic                       free_in,
	output logic                       hit_out,
	output logic                       free_out,
	input  csrt_pkg::tok_t             tok_in,
	output csrt_pkg::tok_t             tok_out,
	output csrt_pkg::ent_t             ent
);

	logic                                 vld_q;
	logic [csrt_pkg::KEY_W-1:0]           key_q;
	logic signed [csrt_pkg::STR_W-1:0]    str_q;
	logic [csrt_pkg::PRIO_W-1:0]          prio_q;
	logic [csrt_pkg::SLOT_W-1:0]          cnt_q;
	csrt_pkg::tok_t                       tok_q;

	logic                                 hit;
	logic                                 sel_ins;
	logic                                 sel_era;
	logic                                 above;
	logic [csrt_pkg::SLOT_W:0]            prio_p1;

	assign hit      = vld_q && (key_q == ctl.key);
	assign hit_out  = hit_in | hit;
	assign free_out = free_in | !vld_q;
	assign sel_era  = hit && !hit_in;
	assign sel_ins  = ctl.any_hit ? sel_era : (!vld_q && !free_in);

	// incoming token ranks above this slot
	assign above = tok_in.vld && ((tok_in.str > str_q) ||
		((tok_in.str == str_q) && (tok_in.slot < idx)));

	assign prio_p1 = {1'b0, cnt_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.op == csrt_pkg::C_INS && sel_ins) begin
			vld_q <= 1'b1;
		end else if (ctl.op == csrt_pkg::C_ERA && sel_era) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			csrt_pkg::C_INS: begin
				if (sel_ins) begin
					key_q  <= ctl.key;
					str_q  <= ctl.str;
					prio_q <= '0;
				end
			end
			csrt_pkg::C_LOAD: begin
				tok_q <= '{vld: vld_q, str: str_q, slot: idx};
				cnt_q <= '0;
			end
			csrt_pkg::C_ROT: begin
				tok_q <= tok_in;
				if (above) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			csrt_pkg::C_FIN: begin
				prio_q <= csrt_pkg::PRIO_W'(prio_p1);
			end
			default: begin
			end
		endcase
	end

	assign tok_out = tok_q;
	assign ent     = '{vld: vld_q, key: key_q, str: str_q, prio: prio_q};

endmodule

// ----- dv/client_strength_rank_table_tb.sv -----
// Testbench for client_strength_rank_table: directed and random insert, erase
// and rank commands, checked against an in-bench model of the slot table.
// Depends on csrt_pkg and the client_strength_rank_table RTL only.
module client_strength_rank_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES    = csrt_pkg::ENTRIES;
	localparam int FUNC_W     = csrt_pkg::FUNC_W;
	localparam int KEY_W      = csrt_pkg::KEY_W;
	localparam int STR_W      = csrt_pkg::STR_W;
	localparam int PRIO_W     = csrt_pkg::PRIO_W;
	localparam int KIND_W     = csrt_pkg::KIND_W;
	localparam int STAT_W     = csrt_pkg::STAT_W;
	localparam int IN_DATA_W  = csrt_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = csrt_pkg::OUT_DATA_W;

	// opcode 3 has no meaning; the block takes the beat and drops it
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int KEY_POOL_SIZE = 24;
	// idle wait after the last expected result, before the summary is printed
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;

	// one result beat as the block should present it
	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [STAT_W-1:0]       status;
		logic [KEY_W-1:0]        key;
		logic signed [STR_W-1:0] str;
		logic [PRIO_W-1:0]       prio;
		logic                    last;
	} table_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]     m_axis_tuser;
	logic                  m_axis_tlast;

	client_strength_rank_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the slot table
	logic                    slot_used     [ENTRIES];
	logic [KEY_W-1:0]        slot_key      [ENTRIES];
	logic signed [STR_W-1:0] slot_strength [ENTRIES];

	table_result_t pending_results[$];
	logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

	int mismatches     = 0;
	int commands_sent  = 0;
	int results_seen   = 0;
	int ranks_done     = 0;
	int empty_ranks    = 0;
	int full_drops     = 0;
	int absent_erases  = 0;
	int unused_ops     = 0;
	int burst_left     = 0;
	bit sender_quiet   = 1'b0;

	// ---------------------------------------------------------------------
	// Expected-result bookkeeping
	// ---------------------------------------------------------------------
	function automatic void push_result(input logic [KIND_W-1:0] kind,
			input logic [STAT_W-1:0] status, input logic [KEY_W-1:0] key,
			input logic signed [STR_W-1:0] str, input logic [PRIO_W-1:0] prio,
			input logic last);
		table_result_t r;
		r.kind   = kind;
		r.status = status;
		r.key    = key;
		r.str    = str;
		r.prio   = prio;
		r.last   = last;
		pending_results = {pending_results, r};
	endfunction

	function automatic int slot_of_key(input logic [KEY_W-1:0] key);
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && slot_key[i] == key) return i;
		end
		return -1;
	endfunction

	// Apply one accepted command to the shadow table and queue its results.
	function automatic void predict_table_op(input logic [FUNC_W-1:0] fn,
			input logic [KEY_W-1:0] key, input logic signed [STR_W-1:0] str);
		int slot;
		int last_slot;
		int above;
		case (fn)
			csrt_pkg::FN_INSERT: begin
				slot = slot_of_key(key);
				// a new key goes to the lowest free slot
				for (int i = 0; i < ENTRIES && slot < 0; i++) begin
					if (!slot_used[i]) slot = i;
				end
				if (slot < 0) begin
					full_drops++;
					push_result(csrt_pkg::KD_STATUS, csrt_pkg::ST_FULL, key, '0, '0,
						1'b1);
				end else begin
					slot_used[slot]     = 1'b1;
					slot_key[slot]      = key;
					slot_strength[slot] = str;
					push_result(csrt_pkg::KD_STATUS, csrt_pkg::ST_DONE, key, str, '0,
						1'b1);
				end
			end
			csrt_pkg::FN_ERASE: begin
				slot = slot_of_key(key);
				if (slot < 0) begin
					absent_erases++;
					push_result(csrt_pkg::KD_STATUS, csrt_pkg::ST_ABSENT, key, '0, '0,
						1'b1);
				end else begin
					slot_used[slot] = 1'b0;
					push_result(csrt_pkg::KD_STATUS, csrt_pkg::ST_DONE, key, '0, '0,
						1'b1);
				end
			end
			csrt_pkg::FN_RANK: begin
				ranks_done++;
				last_slot = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i]) last_slot = i;
				end
				if (last_slot < 0) begin
					empty_ranks++;
					push_result(csrt_pkg::KD_EMPTY, csrt_pkg::ST_DONE, '0, '0, '0, 1'b1);
				end
				for (int i = 0; i <= last_slot; i++) begin
					if (!slot_used[i]) continue;
					// stronger slots, and equal ones in lower slots, rank above
					above = 0;
					for (int j = 0; j < ENTRIES; j++) begin
						if (!slot_used[j] || j == i) continue;
						if (slot_strength[j] > slot_strength[i] ||
								(slot_strength[j] == slot_strength[i] && j < i))
							above++;
					end
					push_result(csrt_pkg::KD_ENTRY, csrt_pkg::ST_DONE, slot_key[i],
						slot_strength[i], PRIO_W'(above + 1), i == last_slot);
				end
			end
			default: unused_ops++;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Command side: bursts of beats separated by random gaps
	// ---------------------------------------------------------------------
	task automatic issue_command(input logic [FUNC_W-1:0] fn,
			input logic [KEY_W-1:0] key, input logic signed [STR_W-1:0] str);
		int gap;
		if (burst_left == 0) begin
			gap = sender_quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		// [1:0] func, [11:2] client_key, [27:12] strength, [31:28] zero
		s_axis_tdata  <= {4'b0000, str, key, fn};
		do @(posedge clk); while (!s_axis_tready);
		predict_table_op(fn, key, str);
		commands_sent++;
	endtask

	// ---------------------------------------------------------------------
	// Result side: the stall pattern is redrawn whenever its random hold count runs out.
	// Mode 0 never stalls, 1 replays a 16-bit mask, 2 and 3 are random.
	// ---------------------------------------------------------------------
	int          stall_left = 0;
	int          stall_mode = 0;
	logic [15:0] stall_mask = 16'hffff;
	logic [3:0]  stall_phase = '0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
			// bit 0 is forced so the mask always holds a ready bit
			stall_mask <= 16'($urandom) | 16'h0001;
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 1'b1;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= stall_mask[stall_phase];
			2: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	// ---------------------------------------------------------------------
	// Result checker: every accepted beat against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		table_result_t got;
		table_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			// tdata: [1:0] status, [11:2] key, [27:12] strength, [32:28] priority
			got.kind   = m_axis_tuser;
			got.status = m_axis_tdata[1:0];
			got.key    = m_axis_tdata[11:2];
			got.str    = m_axis_tdata[27:12];
			got.prio   = m_axis_tdata[32:28];
			got.last   = m_axis_tlast;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected beat kind=%0d st=%0d key=%0d",
						$realtime, got.kind, got.status, got.key,
						" str=%0d pri=%0d last=%0b", got.str, got.prio, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.status !== want.status ||
						got.key !== want.key || got.str !== want.str ||
						got.prio !== want.prio || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: mismatch exp kind=%0d st=%0d key=%0d str=%0d",
							$realtime, want.kind, want.status, want.key, want.str);
						$write(" pri=%0d last=%0b", want.prio, want.last);
						$write(" | got kind=%0d st=%0d key=%0d str=%0d",
							got.kind, got.status, got.key, got.str);
						$display(" pri=%0d last=%0b", got.prio, got.last);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// rank and erase on a fresh table, plus the ignored opcode
	task automatic test_empty_table();
		issue_command(csrt_pkg::FN_RANK, 10'd0, 16'sd0);
		issue_command(FN_UNUSED, 10'h3ff, -16'sd1);
		issue_command(csrt_pkg::FN_ERASE, 10'd1023, 16'sd0);
	endtask

	// extreme keys and strengths, a three-way tie, update and erase of a key
	task automatic test_extremes();
		issue_command(csrt_pkg::FN_INSERT, 10'd0, -16'sd32768);
		issue_command(csrt_pkg::FN_INSERT, 10'd1023, 16'sd32767);
		issue_command(csrt_pkg::FN_INSERT, 10'd512, 16'sd32767);
		issue_command(csrt_pkg::FN_INSERT, 10'd0, 16'sd32767);
		issue_command(csrt_pkg::FN_ERASE, 10'd1023, 16'sd0);
		issue_command(csrt_pkg::FN_RANK, 10'd0, 16'sd0);
	endtask

	// fill every slot, then a new key is dropped while an update still lands
	task automatic test_full_table();
		logic signed [STR_W-1:0] str;
		for (int i = 0; i < ENTRIES - 2; i++) begin
			// small spread so that several slots tie
			str = (i == 5) ? -16'sd32768 : STR_W'($urandom_range(0, 4)) - 16'sd2;
			issue_command(csrt_pkg::FN_INSERT, KEY_W'(100 + i), str);
		end
		issue_command(csrt_pkg::FN_INSERT, 10'd1000, 16'sd1234);
		issue_command(csrt_pkg::FN_INSERT, 10'd512, -16'sd32768);
		issue_command(csrt_pkg::FN_RANK, 10'd0, 16'sd0);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		// mostly a small pool so that updates and erases hit stored keys
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		return KEY_W'($urandom);
	endfunction

	function automatic logic signed [STR_W-1:0] pick_strength();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2, 3, 4: return STR_W'($urandom_range(0, 6)) - 16'sd3;
			default: return STR_W'($urandom);
		endcase
	endfunction

	// random traffic with the given mix; opcode 3 beats are extra
	task automatic test_random_traffic(input int n_items, input int ins_pct,
			input int era_pct);
		int r;
		int counted;
		counted = 0;
		while (counted < n_items) begin
			if (counted % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 4) begin
				issue_command(FN_UNUSED, KEY_W'($urandom), STR_W'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < ins_pct)
					issue_command(csrt_pkg::FN_INSERT, pick_key(), pick_strength());
				else if (r < ins_pct + era_pct)
					issue_command(csrt_pkg::FN_ERASE, pick_key(), STR_W'($urandom));
				else
					issue_command(csrt_pkg::FN_RANK, KEY_W'($urandom), STR_W'($urandom));
				counted++;
			end
		end
		sender_quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
		for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_extremes();
		test_full_table();
		// first fill-leaning so the table runs full, then drain-leaning
		test_random_traffic(150, 55, 20);
		test_random_traffic(110, 25, 50);
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands (%0d ranks, %0d on an empty table, %0d opcode-3 beats);",
			commands_sent, ranks_done, empty_ranks, unused_ops);
		$display("checked %0d result beats, %0d full drops, %0d absent erases, %0d errors.",
			results_seen, full_drops, absent_erases, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

endmodule
